/* rtl/core/pctq_pkg.sv */
// types and codes shared by the per-cpu task queue engine
package pctq_pkg;

    // task and cpu counts, fixed by the field widths of the beats
    localparam int NUM_TASKS = 64;
    localparam int NUM_CPUS  = 8;

    localparam logic [2:0] CMD_INIT   = 3'd0;
    localparam logic [2:0] CMD_SCHED  = 3'd1;
    localparam logic [2:0] CMD_START  = 3'd2;
    localparam logic [2:0] CMD_FINISH = 3'd3;
    localparam logic [2:0] CMD_KILL   = 3'd4;
    localparam logic [2:0] CMD_MIG    = 3'd5;
    localparam logic [2:0] CMD_QUERY  = 3'd6;

    localparam logic [2:0] ST_DONE    = 3'd0;
    localparam logic [2:0] ST_EMPTY   = 3'd1;
    localparam logic [2:0] ST_ERR     = 3'd2;
    localparam logic [2:0] ST_IGN     = 3'd3;
    localparam logic [2:0] ST_KILLRUN = 3'd4;

    localparam logic [0:0] REG_ENABLE = 1'b0;

    typedef struct packed {
        logic [2:0] cmd;
        logic [5:0] task_id;
        logic [2:0] target_cpu;
        logic [2:0] local_cpu;
    } req_t;

    typedef struct packed {
        logic [2:0] status;
        logic       dispatch_valid;
        logic [5:0] dispatched_task;
        logic [7:0] notify_mask;
        logic       queue_empty;
    } rsp_t;

endpackage

/* rtl/core/per_cpu_task_queue_engine.sv */
// top level: per-cpu fifo task queues kept as doubly linked lists in memory
// rsp_valid rises once the command has run through decode and, where needed, link read, unlink
//   and append, repeated per moved task for migrate, and the previous response has been taken
// one command at a time, next beat taken in the cycle after the result loads; the link and
//   target memory read-modify-write sequence sets the rate
// reset: all queues empty, no task queued, running or dead, enable cleared; links undefined
module per_cpu_task_queue_engine (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             req_valid,
    output logic             req_ready,
    input  pctq_pkg::req_t   req,
    output logic             rsp_valid,
    input  logic             rsp_ready,
    output pctq_pkg::rsp_t   rsp,
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [2:0]       paddr,
    input  logic [31:0]      pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    localparam int NUM_TASKS = pctq_pkg::NUM_TASKS;
    localparam int NUM_CPUS  = pctq_pkg::NUM_CPUS;

    // task link width holds the empty marker, index width addresses the memories
    localparam int TW = $clog2(NUM_TASKS + 1);
    localparam int TI = $clog2(NUM_TASKS);
    localparam int CW = $clog2(NUM_CPUS + 1);
    localparam int CI = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;
    localparam logic [TW-1:0] NO_TASK = TW'(NUM_TASKS);
    localparam logic [CW-1:0] NO_CPU  = CW'(NUM_CPUS);

    // sequencer states
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DEC  = 3'd1;
    localparam logic [2:0] S_RM   = 3'd2;
    localparam logic [2:0] S_AP1  = 3'd3;
    localparam logic [2:0] S_AP2  = 3'd4;
    localparam logic [2:0] S_MIG  = 3'd5;
    localparam logic [2:0] S_FIN  = 3'd6;

    // link and target memories, no reset: only used for queued or running tasks
    logic [TW-1:0] next_mem [NUM_TASKS];
    logic [TW-1:0] prev_mem [NUM_TASKS];
    logic [CW-1:0] tgt_mem  [NUM_TASKS];
    logic [TW-1:0] nrd_reg;
    logic [TW-1:0] prd_reg;
    logic [CW-1:0] trd_reg;

    logic          rd_en;
    logic [TI-1:0] rd_addr;
    logic          nw_en, pw_en, tw_en;
    logic [TI-1:0] nw_addr, pw_addr, tw_addr;
    logic [TW-1:0] nw_data, pw_data;
    logic [CW-1:0] tw_data;

    logic [2:0]  state_reg, state_next;
    logic        enable_reg, enable_next;
    logic [2:0]  cmd_reg, cmd_next;
    logic [5:0]  tid_reg, tid_next;
    logic [2:0]  tcpu_reg, tcpu_next;
    logic [2:0]  lcpu_reg, lcpu_next;
    logic [TW-1:0] t_reg, t_next;
    logic [CW-1:0] c_reg, c_next;
    logic [TW-1:0] last_reg, last_next;
    pctq_pkg::rsp_t res_reg, res_next;
    pctq_pkg::rsp_t rsp_reg, rsp_next;
    logic        rsp_valid_reg, rsp_valid_next;

    // per-task flags and per-cpu list ends
    logic [NUM_TASKS-1:0] queued_reg, queued_next;
    logic [NUM_TASKS-1:0] running_reg, running_next;
    logic [NUM_TASKS-1:0] dead_reg, dead_next;
    logic [TW-1:0] head_reg [NUM_CPUS];
    logic [TW-1:0] head_next [NUM_CPUS];
    logic [TW-1:0] tail_reg [NUM_CPUS];
    logic [TW-1:0] tail_next [NUM_CPUS];

    // notify bit, dropped for cpus beyond the mask
    function automatic logic [7:0] cpu_bit(input logic [7:0] c);
        logic [7:0] m;
        m = '0;
        if (32'(c) < NUM_CPUS && c < 8'd8) begin
            m = 8'd1 << c[2:0];
        end
        return m;
    endfunction

    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;
    assign pready    = 1'b1;
    assign prdata    = (paddr[2] == pctq_pkg::REG_ENABLE) ? {31'd0, enable_reg} : 32'd0;

    // sequencer: decode, read links, unlink, append, repeat for migrate
    always_comb
    begin
        logic          t_ok;
        logic [TW-1:0] tsel;
        logic [TW-1:0] h;
        logic [TI-1:0] ti;
        logic [CI-1:0] ci;
        logic          do_rm;
        logic [TW-1:0] p, n;

        state_next     = state_reg;
        enable_next    = enable_reg;
        cmd_next       = cmd_reg;
        tid_next       = tid_reg;
        tcpu_next      = tcpu_reg;
        lcpu_next      = lcpu_reg;
        t_next         = t_reg;
        c_next         = c_reg;
        last_next      = last_reg;
        res_next       = res_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg;
        queued_next    = queued_reg;
        running_next   = running_reg;
        dead_next      = dead_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        rd_en   = 1'b0;
        rd_addr = '0;
        nw_en   = 1'b0;
        nw_addr = '0;
        nw_data = '0;
        pw_en   = 1'b0;
        pw_addr = '0;
        pw_data = '0;
        tw_en   = 1'b0;
        tw_addr = '0;
        tw_data = '0;
        do_rm   = 1'b0;
        p = prd_reg;
        n = nrd_reg;

        t_ok = (32'(tid_reg) < NUM_TASKS);
        tsel = TW'(tid_reg);
        ti   = t_reg[TI-1:0];
        h    = '0;
        ci   = '0;

        if (psel && penable && pwrite && (paddr[2] == pctq_pkg::REG_ENABLE)) begin
            enable_next = pwdata[0];
        end
        if (rsp_valid_reg && rsp_ready) begin
            rsp_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (req_valid) begin
                    cmd_next   = req.cmd;
                    tid_next   = req.task_id;
                    tcpu_next  = req.target_cpu;
                    lcpu_next  = req.local_cpu;
                    res_next   = '0;
                    state_next = S_DEC;
                end
            end
            S_DEC:
            begin
                state_next = S_FIN;
                case (cmd_reg)
                    pctq_pkg::CMD_INIT, pctq_pkg::CMD_KILL:
                    begin
                        if (!t_ok) begin
                            res_next.status = pctq_pkg::ST_IGN;
                        end else begin
                            t_next = tsel; rd_en = 1'b1; rd_addr = tsel[TI-1:0];
                            state_next = S_RM;
                        end
                    end
                    pctq_pkg::CMD_SCHED:
                    begin
                        if (!t_ok || 32'(tcpu_reg) >= NUM_CPUS || !enable_reg ||
                            dead_reg[tsel[TI-1:0]]) begin
                            res_next.status = pctq_pkg::ST_IGN;
                        end else begin
                            t_next = tsel; rd_en = 1'b1; rd_addr = tsel[TI-1:0];
                            state_next = S_RM;
                        end
                    end
                    pctq_pkg::CMD_START:
                    begin
                        if (32'(lcpu_reg) >= NUM_CPUS) begin
                            res_next.status = pctq_pkg::ST_IGN;
                        end else begin
                            h = head_reg[CI'(lcpu_reg)];
                            if (h == NO_TASK) begin
                                res_next.status = pctq_pkg::ST_EMPTY;
                            end else if (dead_reg[h[TI-1:0]] || running_reg[h[TI-1:0]]) begin
                                res_next.status = pctq_pkg::ST_ERR;
                            end else begin
                                t_next = h; rd_en = 1'b1; rd_addr = h[TI-1:0];
                                state_next = S_RM;
                            end
                        end
                    end
                    pctq_pkg::CMD_FINISH:
                    begin
                        if (!t_ok) begin
                            res_next.status = pctq_pkg::ST_IGN;
                        end else if (!running_reg[tsel[TI-1:0]]) begin
                            res_next.status = pctq_pkg::ST_ERR;
                        end else begin
                            t_next = tsel; rd_en = 1'b1; rd_addr = tsel[TI-1:0];
                            state_next = S_RM;
                        end
                    end
                    pctq_pkg::CMD_MIG:
                    begin
                        if (32'(tcpu_reg) >= NUM_CPUS || 32'(lcpu_reg) >= NUM_CPUS) begin
                            res_next.status = pctq_pkg::ST_IGN;
                        end else if (tcpu_reg != lcpu_reg) begin
                            state_next = S_MIG;
                        end
                    end
                    pctq_pkg::CMD_QUERY:
                    begin
                        if (32'(tcpu_reg) >= NUM_CPUS) begin
                            res_next.status      = pctq_pkg::ST_IGN;
                            res_next.queue_empty = 1'b1;
                        end else begin
                            res_next.queue_empty = (head_reg[CI'(tcpu_reg)] == NO_TASK);
                        end
                    end
                    default:
                    begin
                        res_next.status = pctq_pkg::ST_IGN;
                    end
                endcase
            end
            S_MIG:
            begin
                h = head_reg[CI'(tcpu_reg)];
                if (h == NO_TASK) begin
                    res_next.notify_mask = cpu_bit(8'(lcpu_reg));
                    state_next = S_FIN;
                end else begin
                    t_next = h; rd_en = 1'b1; rd_addr = h[TI-1:0];
                    state_next = S_RM;
                end
            end
            S_RM:
            begin
                state_next = S_FIN;
                tw_addr = ti;
                case (cmd_reg)
                    pctq_pkg::CMD_INIT:
                    begin
                        do_rm = 1'b1;
                        tw_en = 1'b1; tw_data = NO_CPU;
                        running_next[ti] = 1'b0;
                        dead_next[ti]    = 1'b0;
                    end
                    pctq_pkg::CMD_SCHED:
                    begin
                        tw_en = 1'b1; tw_data = CW'(tcpu_reg);
                        if (!running_reg[ti]) begin
                            do_rm  = 1'b1;
                            c_next = CW'(tcpu_reg);
                            res_next.notify_mask = cpu_bit(8'(tcpu_reg));
                            state_next = S_AP1;
                        end
                    end
                    pctq_pkg::CMD_START:
                    begin
                        if (trd_reg != CW'(lcpu_reg)) begin
                            res_next.status = pctq_pkg::ST_ERR;
                        end else begin
                            do_rm = 1'b1;
                            tw_en = 1'b1; tw_data = NO_CPU;
                            running_next[ti] = 1'b1;
                            res_next.dispatch_valid  = 1'b1;
                            res_next.dispatched_task = 6'(t_reg);
                        end
                    end
                    pctq_pkg::CMD_FINISH:
                    begin
                        running_next[ti] = 1'b0;
                        if (trd_reg < NO_CPU) begin
                            if (dead_reg[ti] || queued_reg[ti]) begin
                                res_next.status = pctq_pkg::ST_ERR;
                            end else begin
                                c_next = trd_reg;
                                res_next.notify_mask = cpu_bit(8'(trd_reg)) |
                                                       cpu_bit(8'(lcpu_reg));
                                state_next = S_AP1;
                            end
                        end else begin
                            res_next.notify_mask = cpu_bit(8'(lcpu_reg));
                        end
                    end
                    pctq_pkg::CMD_KILL:
                    begin
                        if (queued_reg[ti]) begin
                            res_next.notify_mask = cpu_bit(8'(trd_reg));
                            do_rm = 1'b1;
                        end
                        tw_en = 1'b1; tw_data = NO_CPU;
                        dead_next[ti] = 1'b1;
                        res_next.status = running_reg[ti] ? pctq_pkg::ST_KILLRUN
                                                          : pctq_pkg::ST_DONE;
                    end
                    pctq_pkg::CMD_MIG:
                    begin
                        do_rm = 1'b1;
                        tw_en = 1'b1; tw_data = CW'(lcpu_reg);
                        c_next = CW'(lcpu_reg);
                        state_next = S_AP1;
                    end
                    default:
                    begin
                        state_next = S_FIN;
                    end
                endcase
                // unlink from the old queue using the links read last cycle
                if (do_rm && queued_reg[ti] && trd_reg < NO_CPU) begin
                    ci = CI'(trd_reg);
                    if (p == NO_TASK) begin
                        head_next[ci] = n;
                    end else begin
                        nw_en = 1'b1; nw_addr = p[TI-1:0]; nw_data = n;
                    end
                    if (n == NO_TASK) begin
                        tail_next[ci] = p;
                    end else begin
                        pw_en = 1'b1; pw_addr = n[TI-1:0]; pw_data = p;
                    end
                    queued_next[ti] = 1'b0;
                end
            end
            S_AP1:
            begin
                ci = CI'(c_reg);
                h  = tail_reg[ci];
                pw_en = 1'b1; pw_addr = ti; pw_data = h;
                nw_en = 1'b1; nw_addr = ti; nw_data = NO_TASK;
                tail_next[ci]   = t_reg;
                queued_next[ti] = 1'b1;
                if (h == NO_TASK) begin
                    head_next[ci] = t_reg;
                    state_next = (cmd_reg == pctq_pkg::CMD_MIG) ? S_MIG : S_FIN;
                end else begin
                    last_next  = h;
                    state_next = S_AP2;
                end
            end
            S_AP2:
            begin
                nw_en = 1'b1; nw_addr = last_reg[TI-1:0]; nw_data = t_reg;
                state_next = (cmd_reg == pctq_pkg::CMD_MIG) ? S_MIG : S_FIN;
            end
            S_FIN:
            begin
                if (!rsp_valid_reg || rsp_ready) begin
                    rsp_valid_next = 1'b1;
                    rsp_next       = res_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // memories: one write port each, registered read
    always_ff @(posedge clk)
    begin
        if (nw_en) begin
            next_mem[nw_addr] <= nw_data;
        end
        if (pw_en) begin
            prev_mem[pw_addr] <= pw_data;
        end
        if (tw_en) begin
            tgt_mem[tw_addr] <= tw_data;
        end
        if (rd_en) begin
            nrd_reg <= next_mem[rd_addr];
            prd_reg <= prev_mem[rd_addr];
            trd_reg <= tgt_mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= S_IDLE;
            enable_reg    <= 1'b0;
            rsp_valid_reg <= 1'b0;
            queued_reg    <= '0;
            running_reg   <= '0;
            dead_reg      <= '0;
            for (int i = 0; i < NUM_CPUS; i++) begin
                head_reg[i] <= NO_TASK;
                tail_reg[i] <= NO_TASK;
            end
        end else begin
            state_reg     <= state_next;
            enable_reg    <= enable_next;
            rsp_valid_reg <= rsp_valid_next;
            queued_reg    <= queued_next;
            running_reg   <= running_next;
            dead_reg      <= dead_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
        end
    end

    // command and result payload
    always_ff @(posedge clk)
    begin
        cmd_reg  <= cmd_next;
        tid_reg  <= tid_next;
        tcpu_reg <= tcpu_next;
        lcpu_reg <= lcpu_next;
        t_reg    <= t_next;
        c_reg    <= c_next;
        last_reg <= last_next;
        res_reg  <= res_next;
        rsp_reg  <= rsp_next;
    end

endmodule
